// File: rtl/core/chull_pkg.sv
// Package for the integer convex hull unit: default sizes, controller states,
// and the command and status groups between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chull_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SORT_INIT,
    ST_SORT_NEXT,
    ST_SORT_KEY,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_CH_INIT,
    ST_CH_NEXT,
    ST_CH_A,
    ST_CH_RD,
    ST_CH_DIF,
    ST_CH_MUL,
    ST_CH_CMP,
    ST_SW_RD,
    ST_SW_W1,
    ST_SW_W2,
    ST_CP_RD,
    ST_CP_WR,
    ST_EM_RD,
    ST_EM_LD
  } state_e;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_KEY,
    WSEL_RDA
  } wsel_e;

  typedef struct packed {
    logic  re_a;
    logic  re_b;
    logic  we;
    wsel_e wsel;
    logic  key_ld;
    logic  dif_ld;
    logic  mul_ld;
    logic  out_ld;
    logic  upper;
  } cmd_t;

  typedef struct packed {
    logic precedes;
    logic not_left;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/chull_dp.sv
// Datapath of the convex hull unit: point memory, key register, sort compare,
// cross-product turn test and the result register.
// Depends on chull_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chull_dp #(
  parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chull_pkg::COORD_BITS_DEF,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int AW = $clog2(MAX_POINTS + 1)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  chull_pkg::cmd_t        cmd_i,
  output chull_pkg::sts_t        sts_o,
  input  wire [AW-1:0]           waddr_i,
  input  wire [AW-1:0]           raddr_a_i,
  input  wire [AW-1:0]           raddr_b_i,
  input  wire [IW-1:0]           load_idx_i,
  input  wire [COORD_BITS-1:0]   load_x_i,
  input  wire [COORD_BITS-1:0]   load_y_i,
  input  wire [AW-1:0]           out_size_i,
  input  wire                    out_drop_i,
  input  wire                    out_last_i,
  input  wire                    out_tready_i,
  output logic                   out_tvalid_o,
  output logic [IW-1:0]          out_index_o,
  output logic [COORD_BITS-1:0]  out_x_o,
  output logic [COORD_BITS-1:0]  out_y_o,
  output logic [AW-1:0]          out_size_o,
  output logic                   out_drop_o,
  output logic                   out_last_o
);

  localparam int CB    = COORD_BITS;
  localparam int DEPTH = MAX_POINTS + 1;
  localparam int EW    = IW + 2 * CB;
  localparam int DW    = CB + 1;
  localparam int PWD   = 2 * DW;

  logic [EW-1:0] mem_q [0:DEPTH-1];
  logic [EW-1:0] rda_q, rdb_q, key_q, wdata;

  logic [IW-1:0] key_idx, ra_idx;
  logic [CB-1:0] key_x, key_y, ra_x, ra_y, rb_x, rb_y;

  logic signed [DW-1:0]  dx1_q, dy1_q, dx2_q, dy2_q;
  logic signed [PWD-1:0] p1_q, p2_q;
  logic                  out_valid_q;

  assign key_idx = key_q[IW-1:0];
  assign key_x   = key_q[IW +: CB];
  assign key_y   = key_q[IW+CB +: CB];
  assign ra_idx  = rda_q[IW-1:0];
  assign ra_x    = rda_q[IW +: CB];
  assign ra_y    = rda_q[IW+CB +: CB];
  assign rb_x    = rdb_q[IW +: CB];
  assign rb_y    = rdb_q[IW+CB +: CB];

  always_comb begin
    case (cmd_i.wsel)
      chull_pkg::WSEL_LOAD: wdata = {load_y_i, load_x_i, load_idx_i};
      chull_pkg::WSEL_KEY:  wdata = key_q;
      chull_pkg::WSEL_RDA:  wdata = rda_q;
      default:              wdata = rda_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    if (cmd_i.re_a) begin
      rda_q <= mem_q[raddr_a_i];
    end
    if (cmd_i.re_b) begin
      rdb_q <= mem_q[raddr_b_i];
    end
    if (cmd_i.key_ld) begin
      key_q <= rda_q;
    end
    if (cmd_i.dif_ld) begin
      dx1_q <= $signed({key_x[CB-1], key_x}) - $signed({ra_x[CB-1], ra_x});
      dy1_q <= $signed({key_y[CB-1], key_y}) - $signed({ra_y[CB-1], ra_y});
      dx2_q <= $signed({rb_x[CB-1], rb_x}) - $signed({ra_x[CB-1], ra_x});
      dy2_q <= $signed({rb_y[CB-1], rb_y}) - $signed({ra_y[CB-1], ra_y});
    end
    if (cmd_i.mul_ld) begin
      p1_q <= dx1_q * dy2_q;
      p2_q <= dy1_q * dx2_q;
    end
  end

  always_comb begin
    if (key_x != ra_x) begin
      sts_o.precedes = cmd_i.upper ? ($signed(key_x) > $signed(ra_x))
                                   : ($signed(key_x) < $signed(ra_x));
    end else if (key_y != ra_y) begin
      sts_o.precedes = cmd_i.upper ? ($signed(key_y) > $signed(ra_y))
                                   : ($signed(key_y) < $signed(ra_y));
    end else begin
      sts_o.precedes = key_idx < ra_idx;
    end
    sts_o.not_left = p1_q <= p2_q;
    sts_o.out_free = !out_valid_q || out_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_index_o <= ra_idx;
      out_x_o     <= ra_x;
      out_y_o     <= ra_y;
      out_size_o  <= out_size_i;
      out_drop_o  <= out_drop_i;
      out_last_o  <= out_last_i;
    end
  end

  assign out_tvalid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/chull_ctrl.sv
// Controller of the convex hull unit: load counting, insertion sort and chain
// sequencing, emission. Drives the datapath through chull_pkg command groups.
// Depends on chull_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chull_ctrl #(
  parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF,
  localparam int IW = $clog2(MAX_POINTS),
  localparam int AW = $clog2(MAX_POINTS + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_last_i,
  output logic             in_ready_o,
  output chull_pkg::cmd_t  cmd_o,
  input  chull_pkg::sts_t  sts_i,
  output logic [AW-1:0]    waddr_o,
  output logic [AW-1:0]    raddr_a_o,
  output logic [AW-1:0]    raddr_b_o,
  output logic [IW-1:0]    load_idx_o,
  output logic [AW-1:0]    out_size_o,
  output logic             out_drop_o,
  output logic             out_last_o
);

  localparam int PW = $clog2(MAX_POINTS + 2);
  localparam logic [PW-1:0] ONE = PW'(1);
  localparam logic [PW-1:0] TWO = PW'(2);

  chull_pkg::state_e state_q, state_d;
  logic [PW-1:0] n_q, n_d, lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic [PW-1:0] s_q, s_d, u_q, u_d, k_q, k_d;
  logic          drop_q, drop_d, upper_q, upper_d;
  logic [PW-1:0] wa, ra, rb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chull_pkg::ST_IDLE;
      n_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      s_q     <= '0;
      u_q     <= '0;
      k_q     <= '0;
      drop_q  <= 1'b0;
      upper_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      s_q     <= s_d;
      u_q     <= u_d;
      k_q     <= k_d;
      drop_q  <= drop_d;
      upper_q <= upper_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    i_d        = i_q;
    j_d        = j_q;
    s_d        = s_q;
    u_d        = u_q;
    k_d        = k_q;
    drop_d     = drop_q;
    upper_d    = upper_q;
    wa         = '0;
    ra         = '0;
    rb         = '0;
    in_ready_o = 1'b0;
    cmd_o        = '0;
    cmd_o.wsel   = chull_pkg::WSEL_LOAD;
    cmd_o.upper  = upper_q;

    case (state_q)
      chull_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (n_q < PW'(MAX_POINTS)) begin
            cmd_o.we   = 1'b1;
            cmd_o.wsel = chull_pkg::WSEL_LOAD;
            wa         = n_q;
            n_d        = n_q + ONE;
          end else begin
            drop_d = 1'b1;
          end
          if (in_last_i) begin
            lo_d    = '0;
            hi_d    = n_d;
            upper_d = 1'b0;
            state_d = chull_pkg::ST_SORT_INIT;
          end
        end
      end
      chull_pkg::ST_SORT_INIT: begin
        i_d     = lo_q + ONE;
        state_d = chull_pkg::ST_SORT_NEXT;
      end
      chull_pkg::ST_SORT_NEXT: begin
        if (i_q >= hi_q) begin
          state_d = chull_pkg::ST_CH_INIT;
        end else begin
          cmd_o.re_a = 1'b1;
          ra         = i_q;
          j_d        = i_q;
          state_d    = chull_pkg::ST_SORT_KEY;
        end
      end
      chull_pkg::ST_SORT_KEY: begin
        cmd_o.key_ld = 1'b1;
        state_d      = chull_pkg::ST_SORT_RD;
      end
      chull_pkg::ST_SORT_RD: begin
        if (j_q == lo_q) begin
          cmd_o.we   = 1'b1;
          cmd_o.wsel = chull_pkg::WSEL_KEY;
          wa         = j_q;
          i_d        = i_q + ONE;
          state_d    = chull_pkg::ST_SORT_NEXT;
        end else begin
          cmd_o.re_a = 1'b1;
          ra         = j_q - ONE;
          state_d    = chull_pkg::ST_SORT_CMP;
        end
      end
      chull_pkg::ST_SORT_CMP: begin
        cmd_o.we = 1'b1;
        wa       = j_q;
        if (sts_i.precedes) begin
          cmd_o.wsel = chull_pkg::WSEL_RDA;
          j_d        = j_q - ONE;
          state_d    = chull_pkg::ST_SORT_RD;
        end else begin
          cmd_o.wsel = chull_pkg::WSEL_KEY;
          i_d        = i_q + ONE;
          state_d    = chull_pkg::ST_SORT_NEXT;
        end
      end
      chull_pkg::ST_CH_INIT: begin
        s_d     = lo_q + ONE;
        i_d     = lo_q + TWO;
        state_d = chull_pkg::ST_CH_NEXT;
      end
      chull_pkg::ST_CH_NEXT: begin
        if (i_q >= hi_q) begin
          if (upper_q) begin
            u_d     = s_q;
            k_d     = '0;
            state_d = chull_pkg::ST_EM_RD;
          end else begin
            state_d = chull_pkg::ST_CP_RD;
          end
        end else begin
          cmd_o.re_a = 1'b1;
          ra         = i_q;
          j_d        = s_q;
          state_d    = chull_pkg::ST_CH_A;
        end
      end
      chull_pkg::ST_CH_A: begin
        cmd_o.key_ld = 1'b1;
        state_d      = chull_pkg::ST_CH_RD;
      end
      chull_pkg::ST_CH_RD: begin
        if (j_q == lo_q) begin
          s_d     = j_q + ONE;
          state_d = chull_pkg::ST_SW_RD;
        end else begin
          cmd_o.re_a = 1'b1;
          cmd_o.re_b = 1'b1;
          ra         = j_q;
          rb         = j_q - ONE;
          state_d    = chull_pkg::ST_CH_DIF;
        end
      end
      chull_pkg::ST_CH_DIF: begin
        cmd_o.dif_ld = 1'b1;
        state_d      = chull_pkg::ST_CH_MUL;
      end
      chull_pkg::ST_CH_MUL: begin
        cmd_o.mul_ld = 1'b1;
        state_d      = chull_pkg::ST_CH_CMP;
      end
      chull_pkg::ST_CH_CMP: begin
        if (sts_i.not_left) begin
          j_d     = j_q - ONE;
          state_d = chull_pkg::ST_CH_RD;
        end else begin
          s_d     = j_q + ONE;
          state_d = chull_pkg::ST_SW_RD;
        end
      end
      chull_pkg::ST_SW_RD: begin
        cmd_o.re_a = 1'b1;
        ra         = s_q;
        state_d    = chull_pkg::ST_SW_W1;
      end
      chull_pkg::ST_SW_W1: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = chull_pkg::WSEL_KEY;
        wa         = s_q;
        state_d    = chull_pkg::ST_SW_W2;
      end
      chull_pkg::ST_SW_W2: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = chull_pkg::WSEL_RDA;
        wa         = i_q;
        i_d        = i_q + ONE;
        state_d    = chull_pkg::ST_CH_NEXT;
      end
      chull_pkg::ST_CP_RD: begin
        cmd_o.re_a = 1'b1;
        ra         = '0;
        state_d    = chull_pkg::ST_CP_WR;
      end
      chull_pkg::ST_CP_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = chull_pkg::WSEL_RDA;
        wa         = hi_q;
        hi_d       = hi_q + ONE;
        lo_d       = s_q;
        upper_d    = 1'b1;
        state_d    = chull_pkg::ST_SORT_INIT;
      end
      chull_pkg::ST_EM_RD: begin
        cmd_o.re_a = 1'b1;
        ra         = k_q;
        state_d    = chull_pkg::ST_EM_LD;
      end
      chull_pkg::ST_EM_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          k_d          = k_q + ONE;
          if (k_q + ONE == u_q) begin
            n_d     = '0;
            drop_d  = 1'b0;
            state_d = chull_pkg::ST_IDLE;
          end else begin
            state_d = chull_pkg::ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = chull_pkg::ST_IDLE;
      end
    endcase
  end

  assign waddr_o    = wa[AW-1:0];
  assign raddr_a_o  = ra[AW-1:0];
  assign raddr_b_o  = rb[AW-1:0];
  assign load_idx_o = n_q[IW-1:0];
  assign out_size_o = u_q[AW-1:0];
  assign out_drop_o = drop_q;
  assign out_last_o = (k_q + ONE == u_q);

endmodule
`default_nettype wire

// File: rtl/core/convex_hull_2d_integer_unit.sv
// Integer 2D convex hull unit (monotone chain). Points load one per cycle.
// On the last point: insertion sort and chain walk through the single point
// memory, once for the lower and once for the upper chain, then emission of
// the hull vertices.
// Reset clears the controller, the point count and the result valid.
// Depends on chull_pkg, chull_ctrl, chull_dp.
`timescale 1ns / 1ps
`default_nettype none
module convex_hull_2d_integer_unit #(
  parameter int MAX_POINTS = chull_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chull_pkg::COORD_BITS_DEF,
  localparam int IW     = $clog2(MAX_POINTS),
  localparam int AW     = $clog2(MAX_POINTS + 1),
  localparam int IN_DW  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_FW = IW + 2 * COORD_BITS + AW + 1,
  localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire [IN_DW-1:0]   s_axis_tdata,   // point_x, point_y
  input  wire               s_axis_tlast,   // last_point
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // hull_index, hull_x, hull_y, hull_size, overflow
  output logic              m_axis_tlast    // last_vertex
);

  chull_pkg::cmd_t         cmd;
  chull_pkg::sts_t         sts;
  logic [AW-1:0]           waddr, raddr_a, raddr_b, size_c, out_size;
  logic [IW-1:0]           load_idx, out_index;
  logic                    drop_c, last_c, out_drop;
  logic [COORD_BITS-1:0]   out_x, out_y;

  chull_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts),
    .waddr_o    (waddr),
    .raddr_a_o  (raddr_a),
    .raddr_b_o  (raddr_b),
    .load_idx_o (load_idx),
    .out_size_o (size_c),
    .out_drop_o (drop_c),
    .out_last_o (last_c)
  );

  chull_dp #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .waddr_i      (waddr),
    .raddr_a_i    (raddr_a),
    .raddr_b_i    (raddr_b),
    .load_idx_i   (load_idx),
    .load_x_i     (s_axis_tdata[COORD_BITS-1:0]),
    .load_y_i     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_size_i   (size_c),
    .out_drop_i   (drop_c),
    .out_last_i   (last_c),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_index_o  (out_index),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_size_o   (out_size),
    .out_drop_o   (out_drop),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DW'({out_drop, out_size, out_y, out_x, out_index});

endmodule
`default_nettype wire
